// File: hdl/psu_pkg.sv
// Package for the PNG scanline unfilter: sizes, filter and register codes,
// the stage item struct and the Paeth predictor function.
// Depends on nothing; every other file of the block but psu_ram uses it.
package psu_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int BYTES_PER_PIXEL = 3;
   localparam int HEIGHT_LIMIT    = 4096;
   localparam int STORE_DEPTH     = MAX_WIDTH * BYTES_PER_PIXEL;
   localparam int IDX_W           = $clog2(STORE_DEPTH);
   localparam int COL_W           = $clog2(MAX_WIDTH);
   localparam int ROW_W           = $clog2(HEIGHT_LIMIT);
   localparam int DIM_W           = 13;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int REG_SEL_BIT     = 2;

   typedef logic [7:0]       byte_type;
   typedef logic [1:0]       chan_type;
   typedef logic [DIM_W-1:0] dim_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [ROW_W-1:0] row_type;

   localparam byte_type FILT_NONE  = 8'd0;
   localparam byte_type FILT_SUB   = 8'd1;
   localparam byte_type FILT_UP    = 8'd2;
   localparam byte_type FILT_AVG   = 8'd3;
   localparam byte_type FILT_PAETH = 8'd4;

   localparam chan_type CHAN_FIRST = 2'd0;
   localparam chan_type CHAN_LAST  = chan_type'(BYTES_PER_PIXEL - 1);

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // One channel byte on its way from the counter stage to reconstruction.
   typedef struct packed {
      byte_type filter;
      byte_type data;
      chan_type chan;
      idx_type  idx;
      logic     a_en;
      logic     b_en;
      logic     row_end;
      logic     frame_end;
   } item_type;

   // Zero counts as one; larger values saturate at the limit.
   function automatic dim_type clamp_dim(dim_type v, dim_type lim);
      dim_type r;
      r = v;
      if (v == '0) begin
         r = dim_type'(1);
      end else if (v > lim) begin
         r = lim;
      end
      return r;
   endfunction

   function automatic byte_type paeth_pick(byte_type a, byte_type b, byte_type c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] pa;
      logic signed [9:0] pb;
      logic signed [9:0] pc;
      byte_type          r;
      sa = signed'({2'b00, a});
      sb = signed'({2'b00, b});
      sc = signed'({2'b00, c});
      // p - a = b - c, p - b = a - c, p - c = a + b - 2c.
      pa = sb - sc;
      pb = sa - sc;
      pc = sa + sb - sc - sc;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) begin
         r = a;
      end else if (pb <= pc) begin
         r = b;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

// File: hdl/psu_if.sv
// Stream interfaces of the PNG scanline unfilter: the byte request channel
// and the reconstructed byte response channel. Depends on psu_pkg.
interface psu_req_if;
   logic               valid;
   logic               ready;
   psu_pkg::byte_type  stream_byte;
   logic               frame_start;

   modport source (output valid, output stream_byte, output frame_start, input ready);
   modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

interface psu_rsp_if;
   logic               valid;
   logic               ready;
   psu_pkg::byte_type  pixel_byte;
   psu_pkg::chan_type  channel;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, output pixel_byte, output channel, output row_end,
                   output frame_end, input ready);
   modport sink   (input valid, input pixel_byte, input channel, input row_end,
                   input frame_end, output ready);
endinterface

// File: hdl/psu_ram.sv
// Generic single-clock RAM: one write port, one read port with registered
// read data. Depends on nothing.
module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/psu_front.sv
// Counter stage of the PNG scanline unfilter: takes request words, tracks
// filter type, row, column and channel, and issues the line store read.
// Depends on psu_pkg and psu_if.
module psu_front (
   input  logic               clock,
   input  logic               reset,
   psu_req_if.sink            req_bus,
   input  psu_pkg::dim_type   width_eff,
   input  psu_pkg::dim_type   height_eff,
   input  logic               s1_advance,
   output logic               s1_valid,
   output psu_pkg::item_type  s1_item,
   output logic               rd_en,
   output psu_pkg::idx_type   rd_addr
);
   import psu_pkg::*;

   byte_type filter_ff, filter_in;
   col_type  col_ff, col_in;
   chan_type chan_ff, chan_in;
   row_type  row_ff, row_in;
   logic     expect_ff, expect_in;
   logic     s1_valid_ff, s1_valid_in;
   item_type item_ff;

   logic     accept;
   logic     take_filter;
   col_type  x;
   idx_type  idx;
   logic     row_end;
   logic     frame_end;
   item_type item_new;

   assign req_bus.ready = !s1_valid_ff || s1_advance;
   assign accept        = req_bus.valid && req_bus.ready;
   // A frame start always turns the word into the filter type of row zero.
   assign take_filter   = req_bus.frame_start || expect_ff;

   always_comb begin
      // A column beyond a narrowed width reuses the last column's store entry.
      if ({1'b0, col_ff} >= width_eff) begin
         x = col_type'(width_eff - dim_type'(1));
      end else begin
         x = col_ff;
      end
      idx       = idx_type'({x, 1'b0}) + idx_type'(x) + idx_type'(chan_ff);
      row_end   = (chan_ff == CHAN_LAST) && (({1'b0, col_ff} + dim_type'(1)) >= width_eff);
      frame_end = row_end && (({1'b0, row_ff} + dim_type'(1)) >= height_eff);

      item_new.filter    = filter_ff;
      item_new.data      = req_bus.stream_byte;
      item_new.chan      = chan_ff;
      item_new.idx       = idx;
      item_new.a_en      = (col_ff != '0);
      item_new.b_en      = (row_ff != '0);
      item_new.row_end   = row_end;
      item_new.frame_end = frame_end;
   end

   always_comb begin
      filter_in = filter_ff;
      col_in    = col_ff;
      chan_in   = chan_ff;
      row_in    = row_ff;
      expect_in = expect_ff;
      if (accept) begin
         if (take_filter) begin
            filter_in = req_bus.stream_byte;
            col_in    = '0;
            chan_in   = CHAN_FIRST;
            expect_in = 1'b0;
            if (req_bus.frame_start) begin
               row_in = '0;
            end
         end else if (row_end) begin
            col_in    = '0;
            chan_in   = CHAN_FIRST;
            expect_in = 1'b1;
            row_in    = frame_end ? '0 : row_ff + row_type'(1);
         end else if (chan_ff == CHAN_LAST) begin
            chan_in = CHAN_FIRST;
            col_in  = col_ff + col_type'(1);
         end else begin
            chan_in = chan_ff + chan_type'(1);
         end
      end
   end

   assign rd_en   = accept && !take_filter;
   assign rd_addr = idx;

   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff   <= FILT_NONE;
         col_ff      <= '0;
         chan_ff     <= CHAN_FIRST;
         row_ff      <= '0;
         expect_ff   <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         filter_ff   <= filter_in;
         col_ff      <= col_in;
         chan_ff     <= chan_in;
         row_ff      <= row_in;
         expect_ff   <= expect_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         item_ff <= item_new;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = item_ff;

`ifndef SYNTHESIS
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(item_ff))
      else $error("stage item changed while waiting for reconstruction");
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.frame_start |=> !expect_ff && col_ff == '0 && row_ff == '0
                                        && chan_ff == CHAN_FIRST)
      else $error("frame start did not restart row and column");
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (32'(rd_addr) < STORE_DEPTH))
      else $error("line store read beyond its depth");
`endif

endmodule

// File: hdl/psu_recon.sv
// Reconstruction stage of the PNG scanline unfilter: applies the row filter
// with the left, above and upper-left bytes, writes the line store back and
// holds the response register. Depends on psu_pkg and psu_if.
module psu_recon (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  psu_pkg::item_type  s1_item,
   input  psu_pkg::byte_type  rd_data,
   output logic               s1_advance,
   output logic               wr_en,
   output psu_pkg::idx_type   wr_addr,
   output psu_pkg::byte_type  wr_data,
   psu_rsp_if.source          rsp_bus
);
   import psu_pkg::*;

   byte_type left_ff  [BYTES_PER_PIXEL];
   byte_type upleft_ff[BYTES_PER_PIXEL];
   logic     out_valid_ff, out_valid_in;
   byte_type out_byte_ff;
   chan_type out_chan_ff;
   logic     out_row_end_ff;
   logic     out_frame_end_ff;

   logic     advance;
   byte_type a, b, c;
   byte_type pred;
   byte_type val;

   assign advance = s1_valid && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      a = s1_item.a_en ? left_ff[s1_item.chan] : '0;
      b = s1_item.b_en ? rd_data : '0;
      c = (s1_item.a_en && s1_item.b_en) ? upleft_ff[s1_item.chan] : '0;
      unique case (s1_item.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = byte_type'(({1'b0, a} + {1'b0, b}) >> 1);
         FILT_PAETH: pred = paeth_pick(a, b, c);
         default:    pred = '0;
      endcase
      val = s1_item.data + pred;
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Left and upper-left bytes are masked at column zero, so they need no clear.
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff[s1_item.chan]   <= val;
         upleft_ff[s1_item.chan] <= b;
         out_byte_ff             <= val;
         out_chan_ff             <= s1_item.chan;
         out_row_end_ff          <= s1_item.row_end;
         out_frame_end_ff        <= s1_item.frame_end;
      end
   end

   assign s1_advance        = advance;
   assign wr_en             = advance;
   assign wr_addr           = s1_item.idx;
   assign wr_data           = val;
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.pixel_byte = out_byte_ff;
   assign rsp_bus.channel   = out_chan_ff;
   assign rsp_bus.row_end   = out_row_end_ff;
   assign rsp_bus.frame_end = out_frame_end_ff;

`ifndef SYNTHESIS
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_frame_end_ff |-> out_row_end_ff)
      else $error("frame end flagged on a word that does not end a row");
   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> out_valid_ff && out_byte_ff == $past(wr_data))
      else $error("line store write without matching response word");
`endif

endmodule

// File: hdl/png_scanline_unfilter_rgb24_core.sv
// PNG scanline unfilter for 8-bit RGB, non-interlaced images.
// req_bus carries the inflated byte stream, one word per byte: each row is a
// filter type byte followed by three channel bytes per pixel; frame_start on
// a word restarts the image and makes that word the filter type of row zero.
// rsp_bus returns one word per channel byte (none for a filter type byte)
// with the reconstructed byte, its channel and row and frame end marks.
// The csr_ port is APB-style: image width at address 0, image height at
// address 4; write them only while no word is in flight.
// A request word is registered in the stage item register, which reads the line
// store, and then in the response register once that register is free.
// Throughput is one word per cycle while rsp_bus takes its words, set by the single
// line store read and write back per channel byte; the left neighbour is three words
// back, so there is no dependency stall.
// When rsp_bus stalls, the response register and the one stage behind it
// fill, and req_bus ready drops until the response is taken.
// Reset (synchronous) empties the pipeline, sets width and height to one and
// waits for a filter type byte. The line store needs no clearing: it is read
// only where the row above wrote it.
// Depends on psu_pkg, psu_if, psu_ram, psu_front and psu_recon.
module png_scanline_unfilter_rgb24_core (
   input  logic                              clock,
   input  logic                              reset,
   psu_req_if.sink                           req_bus,
   psu_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [psu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [psu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import psu_pkg::*;

   dim_type  width_ff;
   dim_type  height_ff;
   dim_type  width_eff;
   dim_type  height_eff;
   logic     csr_write;

   logic     s1_valid;
   item_type s1_item;
   logic     s1_advance;
   logic     rd_en;
   idx_type  rd_addr;
   byte_type rd_data;
   logic     wr_en;
   idx_type  wr_addr;
   byte_type wr_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dim_type'(1);
         height_ff <= dim_type'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[REG_SEL_BIT])
            REG_WIDTH:  width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[DIM_W-1:0];
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[REG_SEL_BIT])
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign width_eff  = clamp_dim(width_ff, dim_type'(MAX_WIDTH));
   assign height_eff = clamp_dim(height_ff, dim_type'(HEIGHT_LIMIT));

   psu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .s1_advance (s1_advance),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   psu_ram #(
      .WIDTH ($bits(byte_type)),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psu_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .rd_data    (rd_data),
      .s1_advance (s1_advance),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("line store read and write hit the same entry in one cycle");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for png_scanline_unfilter_rgb24_core. It streams filtered RGB rows,
// predicts every reconstructed byte with its own unfilter model and compares the response words.
// Depends on psu_pkg, psu_if and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import psu_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTS   = 100;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

   typedef struct packed {
      byte_type pixel;
      chan_type chan;
      logic     row_end;
      logic     frame_end;
   } pixel_word_type;

   class rgb_unfilter_checker;
      byte_type       line_store [STORE_DEPTH];
      byte_type       left_px [BYTES_PER_PIXEL];
      byte_type       upleft_px [BYTES_PER_PIXEL];
      byte_type       row_filter;
      int unsigned    col;
      int unsigned    chn;
      int unsigned    row;
      bit             want_filter;
      dim_type        width_reg;
      dim_type        height_reg;
      pixel_word_type pending_bytes [$];
      int             errors;
      int             bytes_sent;
      int             words_checked;

      function new();
         foreach (line_store[i]) line_store[i] = '0;
         row_filter    = FILT_NONE;
         row           = 0;
         width_reg     = dim_type'(1);
         height_reg    = dim_type'(1);
         errors        = 0;
         bytes_sent    = 0;
         words_checked = 0;
         begin_row();
      endfunction

      function void begin_row();
         foreach (left_px[i]) begin
            left_px[i]   = '0;
            upleft_px[i] = '0;
         end
         col         = 0;
         chn         = 0;
         want_filter = 1'b1;
      endfunction

      function int unsigned clamp_size(dim_type v, int unsigned lim);
         int unsigned r;
         r = v;
         if (r == 0) r = 1;
         if (r > lim) r = lim;
         return r;
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function byte_type paeth_choice(byte_type a, byte_type b, byte_type c);
         int p;
         int da;
         int db;
         int dc;
         p  = int'(a) + int'(b) - int'(c);
         da = p - int'(a);
         db = p - int'(b);
         dc = p - int'(c);
         if (da < 0) da = -da;
         if (db < 0) db = -db;
         if (dc < 0) dc = -dc;
         if (da <= db && da <= dc) return a;
         if (db <= dc) return b;
         return c;
      endfunction

      function void take_stream_byte(byte_type data, logic frame_start);
         int unsigned    w;
         int unsigned    h;
         int unsigned    x;
         int unsigned    ch;
         int unsigned    idx;
         int unsigned    pred;
         byte_type       a;
         byte_type       b;
         byte_type       c;
         byte_type       val;
         pixel_word_type word;
         bytes_sent++;
         w = clamp_size(width_reg, MAX_WIDTH);
         h = clamp_size(height_reg, HEIGHT_LIMIT);
         if (frame_start) begin
            row = 0;
            begin_row();
         end
         if (want_filter) begin
            row_filter = data;
            begin_row();
            want_filter = 1'b0;
            return;
         end
         // A column left over from a wider setting lands on the last store entry.
         x   = (col >= w) ? w - 1 : col;
         ch  = chn;
         idx = x * BYTES_PER_PIXEL + ch;
         a   = (col > 0) ? left_px[ch] : '0;
         b   = (row > 0) ? line_store[idx] : '0;
         c   = (col > 0 && row > 0) ? upleft_px[ch] : '0;
         case (row_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (int'(a) + int'(b)) >> 1;
            FILT_PAETH: pred = paeth_choice(a, b, c);
            default:    pred = 0;
         endcase
         val              = byte_type'(data + pred);
         upleft_px[ch]    = b;
         left_px[ch]      = val;
         line_store[idx]  = val;
         word.pixel       = val;
         word.chan        = chan_type'(ch);
         word.row_end     = (ch == BYTES_PER_PIXEL - 1) && (col + 1 >= w);
         word.frame_end   = word.row_end && (row + 1 >= h);
         if (ch == BYTES_PER_PIXEL - 1) begin
            chn = 0;
            col++;
         end else begin
            chn = ch + 1;
         end
         if (word.row_end) begin
            row = word.frame_end ? 0 : row + 1;
            begin_row();
         end
         pending_bytes.push_back(word);
      endfunction

      task check_pixel_word(pixel_word_type got);
         pixel_word_type want;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("response word %h arrived with nothing expected", got));
            return;
         end
         want = pending_bytes.pop_front();
         words_checked++;
         if (got.pixel !== want.pixel)
            report_mismatch($sformatf("word %0d pixel_byte %h, expected %h",
                                      words_checked, got.pixel, want.pixel));
         if (got.chan !== want.chan)
            report_mismatch($sformatf("word %0d channel %0d, expected %0d",
                                      words_checked, got.chan, want.chan));
         if (got.row_end !== want.row_end)
            report_mismatch($sformatf("word %0d row_end %b, expected %b",
                                      words_checked, got.row_end, want.row_end));
         if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("word %0d frame_end %b, expected %b",
                                      words_checked, got.frame_end, want.frame_end));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   psu_req_if req_bus ();
   psu_rsp_if rsp_bus ();

   rgb_unfilter_checker sb = new();
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          settings_used = 0;
   int unsigned cycles = 0;

   png_scanline_unfilter_rgb24_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Run stopped by the cycle limit after %0d cycles.", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: check each accepted word, then pick the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_pixel_word(pixel_word_type'({rsp_bus.pixel_byte, rsp_bus.channel,
                                                  rsp_bus.row_end, rsp_bus.frame_end}));
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_byte(byte_type data, logic fs);
      req_bus.valid       <= 1'b1;
      req_bus.stream_byte <= data;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (!req_bus.ready);
      sb.take_stream_byte(data, fs);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
   endtask

   // Writes one register, reads it back in the following transfer, then releases the bus.
   task automatic write_register(logic [CSR_ADDR_W-1:0] addr, int unsigned value);
      logic [CSR_DATA_W-1:0] wdata;
      wdata = CSR_DATA_W'(value) | (CSR_DATA_W'($urandom) << DIM_W);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_WIDTH) sb.width_reg = dim_type'(wdata);
      else sb.height_reg = dim_type'(wdata);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[DIM_W-1:0] !== wdata[DIM_W-1:0])
         sb.report_mismatch($sformatf("register at %0d reads %h, expected %h",
                                      addr, csr_prdata[DIM_W-1:0], wdata[DIM_W-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      // A trailing filter byte leaves no word behind, so give it time to pass.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned w, int unsigned h, int count, int fs_permille);
      bit       grows;
      logic     fs;
      byte_type data;
      // A wider row would read line store entries the row above never wrote,
      // so a growing width always starts a fresh image.
      grows = sb.clamp_size(dim_type'(w), MAX_WIDTH) > sb.clamp_size(sb.width_reg, MAX_WIDTH);
      drain_pipeline();
      write_register(ADDR_WIDTH, w);
      write_register(ADDR_HEIGHT, h);
      settings_used++;
      for (int i = 0; i < count; i++) begin
         fs = (i == 0 && grows) || ($urandom_range(999) < fs_permille);
         if (fs || sb.want_filter) begin
            // Mostly the five defined filters, now and then an unknown type.
            if ($urandom_range(9) == 0) data = byte_type'($urandom_range(255));
            else data = byte_type'($urandom_range(FILT_PAETH));
         end else begin
            case ($urandom_range(7))
               0:       data = 8'h00;
               1:       data = 8'hFF;
               default: data = byte_type'($urandom_range(255));
            endcase
         end
         send_byte(data, fs);
      end
      req_bus.valid <= 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.stream_byte <= '0;
      req_bus.frame_start <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 12;
      rx_idle_pct = 78;
      // Directed rows on a one pixel wide, four row image: every filter, byte extremes,
      // the wrap after the last row, unknown filter types and a restart in mid-row.
      run_phase(1, 4, 0, 0);
      send_byte(FILT_NONE, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(FILT_UP, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(FILT_AVG, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(FILT_PAETH, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hFF, 1'b0); send_byte(8'h12, 1'b0); send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(FILT_SUB, 1'b0); send_byte(8'hAB, 1'b0);
      send_byte(8'h05, 1'b1); send_byte(8'hFE, 1'b0); send_byte(8'h01, 1'b0);
      send_byte(8'hC3, 1'b0);
      req_bus.valid <= 1'b0;

      run_phase(3, 4, 250, 20);
      run_phase(0, 0, 120, 20);
      run_phase(8, 5, 250, 20);

      tx_idle_pct = 78;
      rx_idle_pct = 12;
      run_phase(5, 3, 250, 20);
      run_phase(2, 8191, 150, 20);
      run_phase(16, 2, 250, 20);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_phase(MAX_WIDTH, 2, 20, 0);
      run_phase(8191, 1, 10, 0);
      run_phase(1, HEIGHT_LIMIT, 20, 0);
      run_phase(7, 3, 200, 20);

      drain_pipeline();
      if (sb.pending_bytes.size() != 0)
         sb.report_mismatch($sformatf("%0d expected words never arrived",
                                      sb.pending_bytes.size()));
      $display("Sent %0d stream bytes and checked %0d reconstructed bytes over %0d settings,",
               sb.bytes_sent, sb.words_checked, settings_used);
      $display("widths and heights from zero up to saturation, all filters and restarts.");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
